// File: rtl/core/asfp_pkg.sv
// ----------------------------------------------------------------------------
// ASCII hex sensor frame parser package
// Frame geometry, tracker phase codes and the slot descriptor shared by the
// frame tracker and the top level.
// ----------------------------------------------------------------------------
package asfp_pkg;

  // Frame geometry.
  localparam int FRAME_CHARS      = 34;
  localparam int NUM_FIELDS       = 6;
  localparam int FIELD_STRIDE     = 5;
  localparam int DIGITS_PER_FIELD = 4;

  // Counter widths.
  localparam int POS_W   = 6;
  localparam int FIELD_W = 4;
  localparam int DIGIT_W = 3;
  localparam int INDEX_W = 3;

  // Framing characters.
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Hex digit ranges and offsets.
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_9      = 8'h39;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_F      = 8'h46;
  localparam logic [7:0] ALPHA_SHIFT = 8'h37;

  typedef enum logic [1:0] {
    PH_HUNT_CR = 2'd0,
    PH_HUNT_LF = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  // What the current character means within the frame.
  typedef struct packed {
    logic                     is_digit;
    logic                     first_digit;
    logic                     last_digit;
    logic [INDEX_W-1:0]       field;
    logic                     frame_last;
  } slot_t;

endpackage

// File: rtl/core/asfp_frame_tracker.sv
// ----------------------------------------------------------------------------
// Frame tracker
// Hunts for CR then LF, then walks the character positions of one frame and
// tells which characters are field digits.
// ----------------------------------------------------------------------------
module asfp_frame_tracker (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output asfp_pkg::slot_t     slot
);

  asfp_pkg::phase_t                   phase, phase_next;
  logic [asfp_pkg::POS_W-1:0]         pos, pos_next;
  logic [asfp_pkg::FIELD_W-1:0]       field_cnt, field_cnt_next;
  logic [asfp_pkg::DIGIT_W-1:0]       digit_cnt, digit_cnt_next;
  logic [asfp_pkg::POS_W:0]           pos_inc;
  logic                               in_field;

  assign pos_inc  = {1'b0, pos} + (asfp_pkg::POS_W+1)'(1);
  assign in_field = (field_cnt < asfp_pkg::FIELD_W'(asfp_pkg::NUM_FIELDS)) &&
                    (digit_cnt < asfp_pkg::DIGIT_W'(asfp_pkg::DIGITS_PER_FIELD));

  // Describe the current character to the decoder.
  always_comb begin
    slot.is_digit    = (phase == asfp_pkg::PH_COLLECT) && in_field;
    slot.first_digit = (digit_cnt == '0);
    slot.last_digit  = (digit_cnt == asfp_pkg::DIGIT_W'(asfp_pkg::DIGITS_PER_FIELD - 1));
    slot.field       = field_cnt[asfp_pkg::INDEX_W-1:0];
    slot.frame_last  = (field_cnt == asfp_pkg::FIELD_W'(asfp_pkg::NUM_FIELDS - 1));
  end

  // Next phase and position.
  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    field_cnt_next = field_cnt;
    digit_cnt_next = digit_cnt;
    case (phase)
      asfp_pkg::PH_HUNT_LF: begin
        if (rx_byte == asfp_pkg::CHAR_LF) begin
          phase_next     = asfp_pkg::PH_COLLECT;
          pos_next       = '0;
          field_cnt_next = '0;
          digit_cnt_next = '0;
        end
      end
      asfp_pkg::PH_COLLECT: begin
        if (pos_inc >= (asfp_pkg::POS_W+1)'(asfp_pkg::FRAME_CHARS)) begin
          phase_next = asfp_pkg::PH_HUNT_CR;
          pos_next   = '0;
        end else begin
          pos_next = pos_inc[asfp_pkg::POS_W-1:0];
        end
        // Field and digit counters follow pos / 5 and pos % 5.
        if (digit_cnt == asfp_pkg::DIGIT_W'(asfp_pkg::FIELD_STRIDE - 1)) begin
          digit_cnt_next = '0;
          field_cnt_next = field_cnt + asfp_pkg::FIELD_W'(1);
        end else begin
          digit_cnt_next = digit_cnt + asfp_pkg::DIGIT_W'(1);
        end
      end
      default: begin
        phase_next = (rx_byte == asfp_pkg::CHAR_CR) ? asfp_pkg::PH_HUNT_LF
                                                    : asfp_pkg::PH_HUNT_CR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= asfp_pkg::PH_HUNT_CR;
      pos       <= '0;
      field_cnt <= '0;
      digit_cnt <= '0;
    end else if (step) begin
      phase     <= phase_next;
      pos       <= pos_next;
      field_cnt <= field_cnt_next;
      digit_cnt <= digit_cnt_next;
    end
  end

endmodule

// File: rtl/core/ascii_hex_sensor_frame_parser.sv
// ----------------------------------------------------------------------------
// ASCII hex sensor frame parser
// Decodes CR/LF framed sensor lines into six 16-bit hex fields.
// ----------------------------------------------------------------------------
// The parser takes one received character per cycle while out_ready does not
// hold back a waiting result. A character is held in an input register,
// decoded against the frame tracker, and any field it completes is captured
// in the output register. Only the fourth digit of a field gives a result;
// every other character gives none. in_ready is high whenever the input
// register is empty or can move on, which it can unless a result is held
// waiting on out_ready.
module ascii_hex_sensor_frame_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [asfp_pkg::INDEX_W-1:0]   field_index,
  output logic [15:0]                    field_value,
  output logic                           field_good,
  output logic                           frame_last
);

  logic             byte_valid;
  logic [7:0]       byte_q;
  logic             advance;
  logic             step;
  asfp_pkg::slot_t  slot;
  logic [15:0]      acc, acc_next;
  logic             good, good_next;
  logic [4:0]       nib_dec;

  // Hex digit decode: bit 4 flags a valid uppercase digit.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= asfp_pkg::CHAR_A && c <= asfp_pkg::CHAR_F) begin
      d = c - asfp_pkg::ALPHA_SHIFT;
      return {1'b1, d[3:0]};
    end
    if (c >= asfp_pkg::CHAR_0 && c <= asfp_pkg::CHAR_9) begin
      d = c - asfp_pkg::CHAR_0;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

  // Handshake: the decode stage moves when the result register is free.
  assign advance  = !out_valid || out_ready;
  assign step     = byte_valid && advance;
  assign in_ready = !byte_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

  asfp_frame_tracker u_tracker (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (byte_q),
    .slot    (slot)
  );

  // Digit accumulation.
  assign nib_dec = hex_nibble(byte_q);

  always_comb begin
    if (slot.first_digit) begin
      acc_next  = {12'h000, nib_dec[3:0]};
      good_next = nib_dec[4];
    end else begin
      acc_next  = {acc[11:0], nib_dec[3:0]};
      good_next = good && nib_dec[4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      good <= 1'b1;
    end else if (step && slot.is_digit) begin
      acc  <= acc_next;
      good <= good_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= slot.is_digit && slot.last_digit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && slot.is_digit && slot.last_digit) begin
      field_index <= slot.field;
      field_value <= good_next ? acc_next : 16'h0000;
      field_good  <= good_next;
      frame_last  <= slot.frame_last;
    end
  end

  // Checks on the parser's own logic.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !byte_valid |-> in_ready)
    else $error("input register empty but in_ready low");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(field_value) && $stable(field_index))
    else $error("stalled result was lost or changed");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !field_good |-> field_value == 16'h0000)
    else $error("bad field carries a nonzero value");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |->
      field_index == asfp_pkg::INDEX_W'(asfp_pkg::NUM_FIELDS - 1))
    else $error("frame_last on a field other than the final one");

endmodule
